[rtl/core/nplkd_pkg.sv]
// shared types and constants for the bigram prompt lookup draft unit
`timescale 1ns / 1ps

package nplkd_pkg;

  localparam int TOKEN_W  = 18;
  localparam int DATA_W   = 24;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] MAX_DRAFT_RST = 5'd8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID    = 2'd0,
    ST_NOMATCH  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LD_B = 6'b000010,
    S_LD_A = 6'b000100,
    S_SCAN = 6'b001000,
    S_COPY = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

endpackage

[rtl/core/ngram_prompt_lookup_draft.sv]
// top level of the bigram prompt lookup draft unit
`timescale 1ns / 1ps

// Append, clear and unused-code items stay in idle and may follow back to back.
// A query keeps the input not ready for its whole run: it fetches the two newest
// tokens and starts the scan, scans the history backward one position at a time,
// then reads each draft token and sends it out, waiting on any output stall.
// The single read port of the history memory serializes these steps. A query after
// overflow, with fewer than two tokens or with a zero draft limit answers in the
// cycle after it is taken, without reading the history. The history needs no
// clearing pass after reset; a clear item takes effect at once.
module ngram_prompt_lookup_draft #(
  parameter int HISTORY_DEPTH = 2048,
  parameter int MAX_DRAFT     = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [nplkd_pkg::DATA_W-1:0]     in_tdata,   // token
  input  logic [nplkd_pkg::FUNC_W-1:0]     in_tuser,   // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [nplkd_pkg::DATA_W-1:0]     out_tdata,  // draft_token
  output logic [nplkd_pkg::STATUS_W-1:0]   out_tuser,  // status
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nplkd_pkg::CFG_W-1:0]      cfg_data
);
  import nplkd_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int LW = $clog2(MAX_DRAFT + 1);
  localparam logic [AW-1:0] ONE_A = 1;
  localparam logic [CW-1:0] ONE_C = 1;
  localparam logic [CW-1:0] TWO_C = 2;
  localparam logic [CW-1:0] THREE_C = 3;
  localparam logic [LW-1:0] ONE_L = 1;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CFG_W-1:0]   max_draft_r;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [TOKEN_W-1:0] a_r, a_nxt;
  logic [TOKEN_W-1:0] b_r, b_nxt;
  logic [TOKEN_W-1:0] prev_r, prev_nxt;
  logic [LW-1:0]      cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TOKEN_W-1:0] out_tok_r, out_tok_nxt;
  status_t            out_st_r, out_st_nxt;
  logic               out_last_r, out_last_nxt;

  logic [LW-1:0]      limit;
  logic               in_xfer;
  func_t              func;
  logic [TOKEN_W-1:0] in_tok;
  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [TOKEN_W-1:0] rd_data;
  logic [CW-1:0]      fill_m1, fill_m2, fill_m3;

  assign func    = func_t'(in_tuser);
  assign in_tok  = in_tdata[TOKEN_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign limit = (32'(max_draft_r) > MAX_DRAFT) ? LW'(MAX_DRAFT) : LW'(max_draft_r);
  assign fill_m1 = fill_r - ONE_C;
  assign fill_m2 = fill_r - TWO_C;
  assign fill_m3 = fill_r - THREE_C;
  assign wr_en = in_xfer && (func == FUNC_APPEND) && (32'(fill_r) < HISTORY_DEPTH);

  nplkd_hist #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_tok),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    prev_nxt      = prev_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_tok_nxt   = out_tok_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (func)
            FUNC_APPEND: begin
              if (wr_en) begin
                fill_nxt = fill_r + ONE_C;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            FUNC_QUERY: begin
              if (ovf_r) begin
                out_valid_nxt = 1'b1;
                out_tok_nxt   = '0;
                out_st_nxt    = ST_OVERFLOW;
                out_last_nxt  = 1'b1;
                state_nxt     = S_HOLD;
              end else if (fill_r < TWO_C || limit == '0) begin
                out_valid_nxt = 1'b1;
                out_tok_nxt   = '0;
                out_st_nxt    = ST_NOMATCH;
                out_last_nxt  = 1'b1;
                state_nxt     = S_HOLD;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = fill_m1[AW-1:0];
                state_nxt = S_LD_B;
              end
            end
            FUNC_CLEAR: begin
              fill_nxt = '0;
              ovf_nxt  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_LD_B: begin
        b_nxt     = rd_data;
        rd_en     = 1'b1;
        rd_addr   = fill_m2[AW-1:0];
        state_nxt = S_LD_A;
      end
      S_LD_A: begin
        a_nxt    = rd_data;
        prev_nxt = rd_data;
        if (fill_r == TWO_C) begin
          out_valid_nxt = 1'b1;
          out_tok_nxt   = '0;
          out_st_nxt    = ST_NOMATCH;
          out_last_nxt  = 1'b1;
          state_nxt     = S_HOLD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = fill_m3[AW-1:0];
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_data == a_r && prev_r == b_r) begin
          rd_en     = 1'b1;
          rd_addr   = pos_r + ONE_A + ONE_A;
          cnt_nxt   = '0;
          state_nxt = S_COPY;
        end else if (pos_r == '0) begin
          out_valid_nxt = 1'b1;
          out_tok_nxt   = '0;
          out_st_nxt    = ST_NOMATCH;
          out_last_nxt  = 1'b1;
          state_nxt     = S_HOLD;
        end else begin
          prev_nxt = rd_data;
          rd_en    = 1'b1;
          rd_addr  = pos_r - ONE_A;
        end
      end
      S_COPY: begin
        out_valid_nxt = 1'b1;
        out_tok_nxt   = rd_data;
        out_st_nxt    = ST_VALID;
        out_last_nxt  = ((cnt_r + ONE_L) == limit) || ((CW'(pos_r) + ONE_C) == fill_r);
        state_nxt     = S_HOLD;
      end
      S_HOLD: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = pos_r + ONE_A;
            cnt_nxt   = cnt_r + ONE_L;
            state_nxt = S_COPY;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign pos_nxt = rd_en ? rd_addr : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      max_draft_r <= MAX_DRAFT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_draft_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    prev_r     <= prev_nxt;
    cnt_r      <= cnt_nxt;
    out_tok_r  <= out_tok_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_tok_r);
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("result pending while idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= HISTORY_DEPTH)
    else $error("fill count beyond history depth");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((CW'(pos_r) + THREE_C) <= fill_r))
    else $error("scan position outside history");

  a_ovf_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == FUNC_QUERY && ovf_r) |=>
      (out_tvalid && out_tlast && out_tuser == ST_OVERFLOW))
    else $error("overflow query not answered at once");
`endif

endmodule

[rtl/core/nplkd_hist.sv]
// token history memory, one write port and one registered read port
`timescale 1ns / 1ps

module nplkd_hist #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [nplkd_pkg::TOKEN_W-1:0]  wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [nplkd_pkg::TOKEN_W-1:0]  rd_data
);
  import nplkd_pkg::*;

  logic [TOKEN_W-1:0] mem [DEPTH];
  logic [TOKEN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[tb/sv/ngram_prompt_lookup_draft_checker.sv]
// checker: tracks the token history, predicts every draft result and compares
`timescale 1ns / 1ps

module ngram_prompt_lookup_draft_checker #(
  parameter int HISTORY_DEPTH = 2048,
  parameter int MAX_DRAFT     = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [nplkd_pkg::DATA_W-1:0]       in_tdata,   // token
  input  logic [nplkd_pkg::FUNC_W-1:0]       in_tuser,   // func
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [nplkd_pkg::DATA_W-1:0]       out_tdata,  // draft_token
  input  logic [nplkd_pkg::STATUS_W-1:0]     out_tuser,  // status
  input  logic                               out_tlast,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [nplkd_pkg::CFG_W-1:0]        cfg_data,
  output int                                 errors,
  output int                                 pending,
  output int                                 beats
);
  import nplkd_pkg::*;

  typedef struct packed {
    logic [TOKEN_W-1:0] tok;
    status_t            st;
    logic               last;
  } draft_beat_t;

  logic [TOKEN_W-1:0] hist [HISTORY_DEPTH];
  int                 fill_cnt;
  logic               overflowed;
  logic [CFG_W-1:0]   draft_max;
  bit                 query_held;
  draft_beat_t        expected_drafts [$];

  always @(posedge clk) begin : track
    int                 p;
    int                 lim;
    int                 cnt;
    int                 k;
    bit                 found;
    logic [TOKEN_W-1:0] ta;
    logic [TOKEN_W-1:0] tb_;
    draft_beat_t        beat;
    if (!rst_n) begin
      fill_cnt   = 0;
      overflowed = 1'b0;
      draft_max  = MAX_DRAFT_RST;
      query_held = 1'b0;
      errors     = 0;
      beats      = 0;
      expected_drafts.delete();
    end else begin
      // a query may wait at the input while an earlier one runs, so predict it once it shows up
      if (in_tvalid && func_t'(in_tuser) == FUNC_QUERY && !query_held) begin
        query_held = 1'b1;
        lim = (int'(draft_max) > MAX_DRAFT) ? MAX_DRAFT : int'(draft_max);
        if (overflowed) begin
          expected_drafts.push_back(draft_beat_t'{'0, ST_OVERFLOW, 1'b1});
        end else if (fill_cnt < 2 || lim == 0) begin
          expected_drafts.push_back(draft_beat_t'{'0, ST_NOMATCH, 1'b1});
        end else begin
          ta    = hist[fill_cnt-2];
          tb_   = hist[fill_cnt-1];
          found = 1'b0;
          p     = fill_cnt - 3;
          while (p >= 0 && !found) begin
            if (hist[p] == ta && hist[p+1] == tb_) found = 1'b1;
            else p--;
          end
          if (!found) begin
            expected_drafts.push_back(draft_beat_t'{'0, ST_NOMATCH, 1'b1});
          end else begin
            cnt = fill_cnt - p - 2;
            if (cnt > lim) cnt = lim;
            for (k = 0; k < cnt; k++) begin
              expected_drafts.push_back(draft_beat_t'{hist[p+2+k], ST_VALID, k == cnt - 1});
            end
          end
        end
      end

      if (out_tvalid && out_tready) begin
        beats++;
        if (expected_drafts.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected draft result: token %0h status %0d last %0d",
                     out_tdata, out_tuser, out_tlast);
          end
        end else begin
          beat = expected_drafts.pop_front();
          if (out_tdata !== {{(DATA_W-TOKEN_W){1'b0}}, beat.tok} ||
              out_tuser !== beat.st || out_tlast !== beat.last) begin
            errors++;
            if (errors <= 10) begin
              $display("draft result %0d: expected token %0h status %0d last %0d,",
                       beats, beat.tok, beat.st, beat.last);
              $display("  got token %0h status %0d last %0d",
                       out_tdata, out_tuser, out_tlast);
            end
          end
        end
      end

      if (cfg_valid && cfg_ready) draft_max = cfg_data;

      if (in_tvalid && in_tready) begin
        query_held = 1'b0;
        case (func_t'(in_tuser))
          FUNC_APPEND: begin
            if (fill_cnt < HISTORY_DEPTH) begin
              hist[fill_cnt] = in_tdata[TOKEN_W-1:0];
              fill_cnt++;
            end else begin
              overflowed = 1'b1;
            end
          end
          FUNC_CLEAR: begin
            fill_cnt   = 0;
            overflowed = 1'b0;
          end
          default: ;
        endcase
      end
    end
    pending <= expected_drafts.size();
  end

endmodule

[tb/sv/ngram_prompt_lookup_draft_tb.sv]
// testbench top: drives token, query and clear traffic and draft limits, gives the verdict
`timescale 1ns / 1ps

module ngram_prompt_lookup_draft_tb;
  import nplkd_pkg::*;

  localparam int HISTORY_DEPTH = 2048;
  localparam int MAX_DRAFT     = 16;
  localparam int STALL_LIMIT   = 12000;
  localparam int HOLD_CYCLES   = 400;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata;
  logic [FUNC_W-1:0]   in_tuser;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;

  int errors;
  int pending;
  int beats;

  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int n_sent = 0;
  int n_app = 0;
  int n_qry = 0;
  int n_clr = 0;
  int n_unused = 0;
  int n_cfg = 0;

  always #1 clk = ~clk;

  ngram_prompt_lookup_draft #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_DRAFT     (MAX_DRAFT)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  ngram_prompt_lookup_draft_checker #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_DRAFT     (MAX_DRAFT)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .beats      (beats)
  );

  // result receiver, with an occasional long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [TOKEN_W-1:0] pick_token();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return TOKEN_W'($urandom());
    endcase
  endfunction

  task automatic send_item(input func_t f, input logic [TOKEN_W-1:0] tok);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 11) gap = 1;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {{(DATA_W-TOKEN_W){1'b0}}, tok};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
    case (f)
      FUNC_APPEND: n_app++;
      FUNC_QUERY:  n_qry++;
      FUNC_CLEAR:  n_clr++;
      default:     n_unused++;
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_draft_limit(input logic [CFG_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic random_phase(input int n_items);
    int                 stop_at;
    int                 kind;
    int                 k;
    int                 j;
    logic [TOKEN_W-1:0] sym [4];
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      for (j = 0; j < 4; j++) sym[j] = pick_token();
      kind = $urandom_range(99);
      if (kind < 40) begin
        // bigram planted twice with a tail between
        if ($urandom_range(1)) send_item(FUNC_CLEAR, pick_token());
        send_item(FUNC_APPEND, sym[0]);
        send_item(FUNC_APPEND, sym[1]);
        k = ($urandom_range(3) == 0) ? $urandom_range(0, 22) : $urandom_range(0, 6);
        for (j = 0; j < k; j++) begin
          send_item(FUNC_APPEND, $urandom_range(1) ? sym[$urandom_range(3)] : pick_token());
        end
        send_item(FUNC_APPEND, sym[0]);
        send_item(FUNC_APPEND, sym[1]);
        send_item(FUNC_QUERY, pick_token());
      end else if (kind < 70) begin
        // small alphabet chatter
        if ($urandom_range(1)) send_item(FUNC_CLEAR, pick_token());
        k = $urandom_range(2, 16);
        for (j = 0; j < k; j++) send_item(FUNC_APPEND, sym[$urandom_range(2)]);
        send_item(FUNC_QUERY, pick_token());
      end else if (kind < 85) begin
        k = $urandom_range(1, 4);
        for (j = 0; j < k; j++) send_item(func_t'($urandom_range(3)), pick_token());
      end else begin
        // short history queries
        send_item(FUNC_CLEAR, pick_token());
        if ($urandom_range(1)) send_item(FUNC_APPEND, sym[0]);
        send_item(FUNC_QUERY, pick_token());
      end
    end
  endtask

  initial begin
    logic [TOKEN_W-1:0] xa;
    logic [TOKEN_W-1:0] xb;
    logic [TOKEN_W-1:0] xc;
    logic [TOKEN_W-1:0] xd;
    logic [CFG_W-1:0]   limits [6];
    int                 ph;
    int                 i;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_APPEND;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, one and two token histories, unused code, match cases, limits
    xa = 18'h2AAAA;
    xb = 18'h15555;
    xc = pick_token();
    send_item(FUNC_QUERY, '1);
    send_item(FUNC_APPEND, '0);
    send_item(FUNC_QUERY, '0);
    send_item(FUNC_APPEND, '1);
    send_item(FUNC_QUERY, pick_token());
    send_item(FUNC_NONE, pick_token());
    send_item(FUNC_CLEAR, pick_token());
    send_item(FUNC_APPEND, xa);
    send_item(FUNC_APPEND, xb);
    send_item(FUNC_APPEND, xc);
    send_item(FUNC_APPEND, xa);
    send_item(FUNC_APPEND, xb);
    send_item(FUNC_QUERY, '0);
    send_item(FUNC_APPEND, xa);
    send_item(FUNC_APPEND, xb);
    send_item(FUNC_QUERY, '1);
    set_draft_limit(5'd0);
    send_item(FUNC_QUERY, pick_token());
    set_draft_limit(5'd1);
    send_item(FUNC_QUERY, pick_token());
    set_draft_limit(5'd16);
    send_item(FUNC_QUERY, pick_token());

    limits = '{5'd31, 5'd2, 5'd17, 5'd8, 5'd0, 5'd0};
    limits[4] = CFG_W'($urandom_range(31));
    limits[5] = CFG_W'($urandom_range(1, 16));
    for (ph = 0; ph < 6; ph++) begin
      set_draft_limit(limits[ph]);
      quiet = (ph == 2);
      random_phase(60);
      if (ph == 0) begin
        // receiver holds off while tokens keep coming behind a query
        xa = pick_token();
        xb = pick_token();
        xc = pick_token();
        xd = pick_token();
        send_item(FUNC_CLEAR, '0);
        send_item(FUNC_APPEND, xa);
        send_item(FUNC_APPEND, xb);
        send_item(FUNC_APPEND, xc);
        send_item(FUNC_APPEND, xd);
        send_item(FUNC_APPEND, xa);
        send_item(FUNC_APPEND, xb);
        hold_req <= hold_req + 1;
        send_item(FUNC_QUERY, pick_token());
        for (i = 0; i < 24; i++) send_item(FUNC_APPEND, pick_token());
        drain();
      end
    end
    quiet = 1'b0;

    // fill the history to the top, then overflow it
    set_draft_limit(5'd16);
    xa = pick_token();
    xb = pick_token();
    send_item(FUNC_CLEAR, '1);
    send_item(FUNC_APPEND, xa);
    send_item(FUNC_APPEND, xb);
    quiet = 1'b1;
    for (i = 2; i < HISTORY_DEPTH - 2; i++) send_item(FUNC_APPEND, pick_token());
    quiet = 1'b0;
    send_item(FUNC_APPEND, xa);
    send_item(FUNC_APPEND, xb);
    send_item(FUNC_QUERY, pick_token());
    for (i = 0; i < 3; i++) send_item(FUNC_APPEND, pick_token());
    send_item(FUNC_QUERY, pick_token());
    send_item(FUNC_NONE, pick_token());
    send_item(FUNC_QUERY, pick_token());
    send_item(FUNC_CLEAR, pick_token());
    send_item(FUNC_QUERY, pick_token());
    send_item(FUNC_APPEND, xa);
    send_item(FUNC_APPEND, xb);
    send_item(FUNC_APPEND, xa);
    send_item(FUNC_APPEND, xb);
    send_item(FUNC_QUERY, pick_token());

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d appends, %0d queries, %0d clears, %0d unused-code items;",
             n_app, n_qry, n_clr, n_unused);
    $display("%0d draft results checked, draft limit written %0d times over 0..31",
             beats, n_cfg);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
